// File: hw/rtl/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types, constants and round functions of the SHA-256 engine.
// ----------------------------------------------------------------------------
package sha_pkg;

    localparam int QueueDepth = 4;

    // One classified transaction from the front part to the back part.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
    } sha_cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_FEED,
        ST_PAD,
        ST_LEN,
        ST_EMIT
    } sha_state_t;

    typedef logic [31:0] word_t;

    localparam word_t InitHash [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PadByte  = 8'h80;
    localparam logic [5:0] LenStart = 6'd56;

    function automatic word_t ror(input word_t v, input int amt);
        ror = (v >> amt) | (v << (32 - amt));
    endfunction

    function automatic word_t sig0(input word_t x);
        sig0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t sig1(input word_t x);
        sig1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
    endfunction

    function automatic word_t bsig0(input word_t x);
        bsig0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
    endfunction

    function automatic word_t bsig1(input word_t x);
        bsig1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
    endfunction

endpackage

// File: hw/rtl/sha_ram.sv
// ----------------------------------------------------------------------------
// sha_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sha_ram #(
    parameter int Width = 8,
    parameter int Depth = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(Depth)-1:0] wr_addr,
    input  logic [Width-1:0]         wr_data,
    input  logic [$clog2(Depth)-1:0] rd_addr,
    output logic [Width-1:0]         rd_data
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

// File: hw/rtl/sha_front.sv
// ----------------------------------------------------------------------------
// sha_front
// Input stage: accepts transactions, drops empty ones, queues the rest.
// ----------------------------------------------------------------------------
module sha_front
    import sha_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [7:0] s_data_byte,
    input  logic       s_has_byte,
    input  logic       s_end_of_message,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       q_valid,
    output sha_cmd_t   q_cmd,
    input  logic       q_pop
);
    localparam int AW = $clog2(QueueDepth);

    sha_cmd_t        fifo_reg [QueueDepth];
    logic [AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]     count_reg, count_next;
    logic            push;

    assign s_ready = (count_reg != (AW+1)'(QueueDepth));
    // Drop transactions that neither carry a byte nor end the message.
    assign push    = s_valid && s_ready && (s_has_byte || s_end_of_message);
    assign q_valid = (count_reg != '0);
    assign q_cmd   = fifo_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !(q_pop && q_valid)) begin
            count_next = count_reg + 1'b1;
        end else if (!push && q_pop && q_valid) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (q_pop && q_valid) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= '{s_data_byte, s_has_byte, s_end_of_message};
        end
    end
endmodule

// File: hw/rtl/sha_back.sv
// ----------------------------------------------------------------------------
// sha_back
// Execution stage: gathers bytes, pads, runs the rounds, emits the digest.
// ----------------------------------------------------------------------------
module sha_back
    import sha_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    input  sha_cmd_t    q_cmd,
    output logic        q_pop,
    output logic [31:0] m_digest_word,
    output logic [2:0]  m_word_index,
    output logic        m_last_word,
    output logic        m_valid,
    input  logic        m_ready
);
    sha_state_t  state_reg, state_next;
    word_t       chain_reg [8];
    word_t       work_reg  [8];
    word_t       win_reg   [16];
    logic [60:0] count_reg;
    logic [6:0]  round_reg;
    logic [5:0]  pad_pos_reg;
    logic        end_pend_reg;  // message ends after the current block
    logic        len_done_reg;  // current block carries the length
    logic        mark_pend_reg; // 0x80 marker still to be written
    logic [2:0]  emit_reg;

    // Block byte store.
    logic       ram_we;
    logic [5:0] ram_waddr, ram_raddr;
    logic [7:0] ram_wdata, ram_rdata;

    sha_ram #(.Width(8), .Depth(64)) u_block (
        .aclk   (aclk),
        .wr_en  (ram_we),
        .wr_addr(ram_waddr),
        .wr_data(ram_wdata),
        .rd_addr(ram_raddr),
        .rd_data(ram_rdata)
    );

    // Round datapath
    word_t w_cur, t1, t2;
    logic [3:0] ti;
    logic [63:0] bits;
    assign ti   = round_reg[3:0];
    assign bits = {count_reg, 3'b000};

    always_comb begin
        if (round_reg < 7'd16) begin
            w_cur = win_reg[ti];
        end else begin
            w_cur = win_reg[ti] + sig0(win_reg[4'(ti + 4'd1)])
                  + win_reg[4'(ti + 4'd9)] + sig1(win_reg[4'(ti + 4'd14)]);
        end
        t1 = work_reg[7] + bsig1(work_reg[4])
           + ((work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]))
           + RoundK[round_reg[5:0]] + w_cur;
        t2 = bsig0(work_reg[0])
           + ((work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
              ^ (work_reg[1] & work_reg[2]));
    end

    // LOAD sweep: round_reg counts 0..64, window writes lag the RAM reads by one address.
    logic [7:0] len_byte;
    always_comb begin
        len_byte = bits[8*(7 - int'(pad_pos_reg[2:0])) +: 8];
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    if (q_cmd.has_byte && count_reg[5:0] == 6'd63) begin
                        state_next = ST_LOAD;
                    end else if (q_cmd.end_of_message) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                if (pad_pos_reg == 6'd63) begin
                    state_next = ST_LOAD;
                end else if (len_done_reg && pad_pos_reg == LenStart - 6'd1) begin
                    state_next = ST_LEN;
                end
            end
            ST_LEN:   if (pad_pos_reg == 6'd63) state_next = ST_LOAD;
            ST_LOAD:  if (round_reg == 7'd64) state_next = ST_ROUND;
            ST_ROUND: if (round_reg == 7'd63) state_next = ST_FEED;
            ST_FEED: begin
                if (!end_pend_reg) begin
                    state_next = ST_IDLE;
                end else if (len_done_reg) begin
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_PAD;
                end
            end
            ST_EMIT:  if (m_ready && emit_reg == 3'd7) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        q_pop     = (state_reg == ST_IDLE) && q_valid;
        ram_we    = 1'b0;
        ram_waddr = pad_pos_reg;
        ram_wdata = 8'h00;
        ram_raddr = round_reg[5:0];
        m_valid   = (state_reg == ST_EMIT);
        if (state_reg == ST_IDLE && q_valid && q_cmd.has_byte) begin
            ram_we    = 1'b1;
            ram_waddr = count_reg[5:0];
            ram_wdata = q_cmd.data_byte;
        end else if (state_reg == ST_PAD) begin
            ram_we    = 1'b1;
            ram_wdata = mark_pend_reg ? PadByte : 8'h00;
        end else if (state_reg == ST_LEN) begin
            ram_we    = 1'b1;
            ram_wdata = len_byte;
        end
    end

    assign m_digest_word = chain_reg[emit_reg];
    assign m_word_index  = emit_reg;
    assign m_last_word   = (emit_reg == 3'd7);

    logic [5:0] first_pad;
    assign first_pad = count_reg[5:0] + 6'(q_cmd.has_byte);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            round_reg     <= '0;
            pad_pos_reg   <= '0;
            end_pend_reg  <= 1'b0;
            len_done_reg  <= 1'b0;
            mark_pend_reg <= 1'b0;
            emit_reg      <= '0;
            for (int i = 0; i < 8; i++) chain_reg[i] <= InitHash[i];
        end else begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_IDLE: begin
                    round_reg <= '0;
                    if (q_valid) begin
                        if (q_cmd.has_byte) count_reg <= count_reg + 61'd1;
                        end_pend_reg  <= q_cmd.end_of_message;
                        mark_pend_reg <= q_cmd.end_of_message;
                        // Pad pointer starts at the 0x80 position.
                        pad_pos_reg   <= first_pad;
                        // A full block compresses first, so padding goes to the next one.
                        len_done_reg  <= (first_pad < LenStart)
                                      && !(q_cmd.has_byte && count_reg[5:0] == 6'd63);
                    end
                end
                ST_PAD: begin
                    pad_pos_reg   <= pad_pos_reg + 6'd1;
                    mark_pend_reg <= 1'b0;
                end
                ST_LEN: begin
                    pad_pos_reg <= pad_pos_reg + 6'd1;
                end
                ST_LOAD: begin
                    if (round_reg != 7'd0) begin
                        win_reg[4'((round_reg - 7'd1) >> 2)]
                            <= {win_reg[4'((round_reg - 7'd1) >> 2)][23:0], ram_rdata};
                    end
                    if (round_reg == 7'd64) begin
                        round_reg <= '0;
                        for (int i = 0; i < 8; i++) work_reg[i] <= chain_reg[i];
                    end else begin
                        round_reg <= round_reg + 7'd1;
                    end
                end
                ST_ROUND: begin
                    round_reg <= round_reg + 7'd1;
                    win_reg[ti] <= w_cur;
                    work_reg[7] <= work_reg[6];
                    work_reg[6] <= work_reg[5];
                    work_reg[5] <= work_reg[4];
                    work_reg[4] <= work_reg[3] + t1;
                    work_reg[3] <= work_reg[2];
                    work_reg[2] <= work_reg[1];
                    work_reg[1] <= work_reg[0];
                    work_reg[0] <= t1 + t2;
                end
                ST_FEED: begin
                    round_reg <= '0;
                    for (int i = 0; i < 8; i++) chain_reg[i] <= chain_reg[i] + work_reg[i];
                    // Second pad block: the 0x80 marker if still pending, then zeros up to the length field.
                    pad_pos_reg  <= '0;
                    len_done_reg <= 1'b1;
                    emit_reg     <= '0;
                end
                ST_EMIT: begin
                    if (m_ready) begin
                        emit_reg <= emit_reg + 3'd1;
                        if (emit_reg == 3'd7) begin
                            for (int i = 0; i < 8; i++) chain_reg[i] <= InitHash[i];
                            count_reg <= '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

// File: hw/rtl/sha256_hash_engine_core.sv
// ----------------------------------------------------------------------------
// sha256_hash_engine_core
// SHA-256 over a byte stream with a queued front end and a round engine.
// ----------------------------------------------------------------------------
// Input channel (s_*): each transaction may append s_data_byte (s_has_byte)
// and may close the message (s_end_of_message); a byte and an end together
// append the byte first. Transactions with neither are dropped at the input.
// A four-entry queue parts the input from the round engine, so transactions
// are taken while the engine compresses or the digest waits.
// Output channel (m_*): eight transactions per message, word 0 first,
// m_last_word on word 7.
// Timing: bytes stream at one per cycle through the queue while the engine
// waits in its idle state; a 64th byte starts a compression (block load,
// 64 rounds, feed-forward) whose length is set by the one-round-per-cycle
// unit and the single block RAM read port. An end of message adds the
// padding fill and one or two compressions before the first digest word.
// Reset (aresetn low, synchronous) empties the queue and restores the
// initial hash values. A stalled m_ready holds the current digest word; the
// queue keeps accepting until it is full.
// ----------------------------------------------------------------------------
module sha256_hash_engine_core
    import sha_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [7:0]  s_data_byte,
    input  logic        s_has_byte,
    input  logic        s_end_of_message,
    input  logic        s_valid,
    output logic        s_ready,
    output logic [31:0] m_digest_word,
    output logic [2:0]  m_word_index,
    output logic        m_last_word,
    output logic        m_valid,
    input  logic        m_ready
);
    logic     q_valid, q_pop;
    sha_cmd_t q_cmd;

    // Front part: classify and queue.
    sha_front u_front (
        .aclk, .aresetn, .s_data_byte, .s_has_byte, .s_end_of_message,
        .s_valid, .s_ready, .q_valid, .q_cmd, .q_pop
    );

    // Back part: pad, compress, emit.
    sha_back u_back (
        .aclk, .aresetn, .q_valid, .q_cmd, .q_pop,
        .m_digest_word, .m_word_index, .m_last_word, .m_valid, .m_ready
    );

`ifndef SYNTHESIS
    // Word index and last flag agree.
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last_word == (m_word_index == 3'd7)))
        else $error("last_word mismatch");
    // Word index advances by one after each accepted word.
    a_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_word) |=>
            (m_valid && m_word_index == $past(m_word_index) + 3'd1))
        else $error("word index skip");
    // Queue is never popped when empty.
    a_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("pop of empty queue");
`endif
endmodule

// File: tb/sv/sha256_digest_checker.sv
// ----------------------------------------------------------------------------
// sha256_digest_checker
// Watches both channels of the SHA-256 engine, predicts every digest word
// from the accepted input transactions and compares each output transaction
// against the oldest predicted word.
// ----------------------------------------------------------------------------
module sha256_digest_checker
    import sha_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [7:0]  s_data_byte,
    input  logic        s_has_byte,
    input  logic        s_end_of_message,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [31:0] m_digest_word,
    input  logic [2:0]  m_word_index,
    input  logic        m_last_word,
    input  logic        m_valid,
    input  logic        m_ready,
    output int          fail_count,
    output int          words_pending
);

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } digest_beat_t;

    localparam word_t IvWords [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t Kconst [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    word_t        hash_state [8];
    logic [7:0]   pending_block [64];
    logic [60:0]  byte_total;
    digest_beat_t expected_words [$];

    function automatic word_t rotr(word_t v, int amt);
        return (v >> amt) | (v << (32 - amt));
    endfunction

    // Fold the 64 pending bytes into the hash state.
    task automatic fold_block();
        word_t w [16];
        word_t a, b, c, d, e, f, g, h, wt, t1, t2, w15, w2;
        for (int i = 0; i < 16; i++) begin
            w[i] = {pending_block[4*i], pending_block[4*i+1],
                    pending_block[4*i+2], pending_block[4*i+3]};
        end
        {a, b, c, d} = {hash_state[0], hash_state[1], hash_state[2], hash_state[3]};
        {e, f, g, h} = {hash_state[4], hash_state[5], hash_state[6], hash_state[7]};
        for (int t = 0; t < 64; t++) begin
            if (t < 16) begin
                wt = w[t];
            end else begin
                w15 = w[(t - 15) & 15];
                w2  = w[(t - 2) & 15];
                wt  = w[t & 15] + (rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3))
                    + w[(t - 7) & 15] + (rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10));
                w[t & 15] = wt;
            end
            t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
               + Kconst[t] + wt;
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
        hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
    endtask

    // Apply one input transaction; queue eight digest words on end of message.
    task automatic absorb(logic [7:0] data, logic has_b, logic eom);
        int          pos;
        logic [63:0] bit_len;
        if (has_b) begin
            pos = byte_total[5:0];
            pending_block[pos] = data;
            byte_total++;
            if (pos == 63) fold_block();
        end
        if (eom) begin
            pos = byte_total[5:0];
            pending_block[pos] = 8'h80;
            for (int i = pos + 1; i < 64; i++) pending_block[i] = 8'h00;
            if (pos >= 56) begin
                fold_block();
                for (int i = 0; i < 64; i++) pending_block[i] = 8'h00;
            end
            bit_len = {byte_total, 3'b000};
            for (int i = 0; i < 8; i++) pending_block[56+i] = bit_len[63-8*i -: 8];
            fold_block();
            for (int i = 0; i < 8; i++) begin
                expected_words.push_back('{hash_state[i], 3'(i), i == 7});
            end
            hash_state = IvWords;
            byte_total = '0;
        end
    endtask

    always @(posedge aclk) begin
        digest_beat_t exp_w;
        if (!aresetn) begin
            hash_state = IvWords;
            byte_total = '0;
            expected_words.delete();
            fail_count = 0;
            words_pending = 0;
        end else begin
            if (s_valid && s_ready) absorb(s_data_byte, s_has_byte, s_end_of_message);
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    $error("unexpected digest word %h", m_digest_word);
                    fail_count++;
                end else begin
                    exp_w = expected_words.pop_front();
                    if (m_digest_word !== exp_w.digest_word) begin
                        $error("digest_word exp %h got %h", exp_w.digest_word, m_digest_word);
                        fail_count++;
                    end
                    if (m_word_index !== exp_w.word_index) begin
                        $error("word_index exp %0d got %0d", exp_w.word_index, m_word_index);
                        fail_count++;
                    end
                    if (m_last_word !== exp_w.last_word) begin
                        $error("last_word exp %0d got %0d", exp_w.last_word, m_last_word);
                        fail_count++;
                    end
                end
            end
            words_pending = expected_words.size();
        end
    end

endmodule

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives byte streams into the SHA-256 engine with random bursts and output
// stalls; the digest checker predicts and compares, this module gives the
// verdict.
// ----------------------------------------------------------------------------
module tb_top;

    logic        aclk;
    logic        aresetn;
    logic [7:0]  s_data_byte;
    logic        s_has_byte;
    logic        s_end_of_message;
    logic        s_valid;
    logic        s_ready;
    logic [31:0] m_digest_word;
    logic [2:0]  m_word_index;
    logic        m_last_word;
    logic        m_valid;
    logic        m_ready;
    int          fail_count;
    int          words_pending;
    int          burst_left;

    sha256_hash_engine_core u_dut (.*);

    sha256_digest_checker u_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Receiver stall pattern: long open stretches, then phases of light and of heavy stalling.
    initial begin
        int phase;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            phase = int'(($time / 4000) % 3);
            if (phase == 0) m_ready <= 1'b1;
            else if (phase == 1) m_ready <= ($urandom_range(0, 3) != 0);
            else m_ready <= ($urandom_range(0, 4) == 0);
        end
    end

    // Present one transaction and hold it until the engine takes it. The
    // sender idles in gaps between bursts of random length.
    task automatic send_txn(logic [7:0] data, logic has_b, logic eom);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        s_data_byte      <= data;
        s_has_byte       <= has_b;
        s_end_of_message <= eom;
        s_valid          <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic send_message(int len, bit noisy);
        for (int i = 0; i < len; i++) begin
            if (noisy && $urandom_range(0, 9) == 0) send_txn(8'($urandom), 1'b0, 1'b0);
            send_txn(8'($urandom), 1'b1, (i == len - 1) && $urandom_range(0, 1));
        end
        send_txn(8'($urandom), 1'b0, 1'b1);
    endtask

    initial begin
        int len;
        aresetn          = 1'b0;
        s_valid          = 1'b0;
        s_data_byte      = '0;
        s_has_byte       = 1'b0;
        s_end_of_message = 1'b0;
        burst_left       = 0;
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;

        // Directed: empty message, byte with end, all-ones and all-zeros
        // bytes, idle transaction, lengths around the padding boundary.
        send_txn(8'h00, 1'b0, 1'b1);
        send_txn(8'hff, 1'b1, 1'b1);
        send_txn(8'h00, 1'b0, 1'b0);
        send_txn(8'h00, 1'b1, 1'b0);
        send_txn(8'h5a, 1'b0, 1'b1);
        for (int i = 0; i < 55; i++) send_txn(8'hff, 1'b1, i == 54);
        for (int i = 0; i < 56; i++) send_txn(8'ha5, 1'b1, i == 55);

        // Hold off until the engine has drained everything.
        s_valid <= 1'b0;
        wait (words_pending == 0);
        @(negedge aclk);

        for (int i = 0; i < 64; i++) send_txn(i[7:0], 1'b1, 1'b0);
        send_txn(8'h00, 1'b0, 1'b1);

        // Random messages, mostly short, a few spanning several blocks.
        repeat (10) begin
            len = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 130)
                                                : $urandom_range(0, 20);
            send_message(len, 1'b1);
        end
        s_valid <= 1'b0;

        wait (words_pending == 0);
        repeat (300) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #10000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// File: sha256_hash_engine_core.f
hw/rtl/sha_pkg.sv
hw/rtl/sha_ram.sv
hw/rtl/sha_front.sv
hw/rtl/sha_back.sv
hw/rtl/sha256_hash_engine_core.sv
tb/sv/sha256_digest_checker.sv
tb/sv/tb_top.sv
